@@ design/mbs_pkg.sv @@
// shared types, codes and helpers for the maze backtracker step block
// no dependencies; imported by every design file of the block but mbs_ram, and by the testbench
package mbs_pkg;

   // command codes
   localparam logic CMD_START = 1'b0;

   // wall side codes
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [15:0] random_value;
   } req_item_type;

   typedef struct packed {
      logic       carved;
      logic [3:0] from_x;
      logic [3:0] from_y;
      logic [1:0] direction;
      logic [3:0] walker_x;
      logic [3:0] walker_y;
      logic       finished;
   } rsp_item_type;

   // remainder by three: base-four digits sum, then fold
   function automatic logic [1:0] mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

endpackage

@@ design/mbs_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module mbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mbs_pick.sv @@
// chooses one free neighbour from the random word
// depends on mbs_pkg
module mbs_pick (
   input  logic [3:0]  free,
   input  logic [15:0] rnd,
   output logic        any,
   output logic [1:0]  dir
);
   import mbs_pkg::*;

   logic [2:0] count;
   logic [1:0] pick;
   logic [1:0] seen;

   assign count = 3'($countones(free));
   assign any   = (count != 3'd0);

   // index among candidates: random word modulo candidate count
   always_comb begin
      case (count)
         3'd2:    pick = {1'b0, rnd[0]};
         3'd3:    pick = mod3_16(rnd);
         3'd4:    pick = rnd[1:0];
         default: pick = 2'd0;
      endcase
   end

   // walk the candidates in order left, right, up, down
   always_comb begin
      seen = 2'd0;
      dir  = DIR_LEFT;
      for (int d = 0; d < 4; d++) begin
         if (free[d]) begin
            if (seen == pick) begin
               dir = 2'(d);
            end
            seen = seen + 2'd1;
         end
      end
   end

endmodule

@@ design/maze_backtracker_step.sv @@
// depth-first backtracking maze generator, one iteration per step word
// depends on mbs_pkg, mbs_ram and mbs_pick
//
// usage
//   req channel: one word per command, cmd start or step plus a random word
//   rsp channel: exactly one word per request, in request order
//   a start word clears the visited map, one cell a cycle over every cell,
//   then returns its response
//   a step word: the left neighbour read is issued on the acceptance edge,
//   then the read phases take the left, right, up and down visited bits in
//   turn from the map's single read port, the last of which also decides and
//   updates walker, stack and counters; the next word is taken only back in
//   idle, so no new word is taken while a step is in work
//   a step after completion answers from idle, back to back unless stalled
//   reset runs the same clearing sweep with req_stall high and no response
//   the response sits in an output register; while rsp_stall is high a new
//   request is still taken and worked on, and its result is parked until the
//   output register frees
//   stack pushes and pops happen at a decide phase; the top entry is next
//   used at a later decide phase, so no forwarding is needed
module maze_backtracker_step #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mbs_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mbs_pkg::rsp_item_type rsp_data
);
   import mbs_pkg::*;

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int AW    = $clog2(CELLS);
   localparam int DW    = $clog2(CELLS + 1);
   localparam int SW    = XW + YW;

   localparam logic [XW-1:0] X_LAST     = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] Y_LAST     = YW'(GRID_HEIGHT - 1);
   localparam logic [AW-1:0] CELL_LAST  = AW'(CELLS - 1);
   localparam logic [DW-1:0] CELL_TOTAL = DW'(CELLS);

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // read phase in which the last neighbour arrives and the step is decided
   localparam logic [2:0] PH_DECIDE = 3'd4;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                                input logic [YW-1:0] cy);
      return AW'(AW'(cy) * AW'(GRID_WIDTH)) + AW'(cx);
   endfunction

   // control state
   logic [1:0]    state_ff,    state_in;
   logic [2:0]    phase_ff,    phase_in;
   logic [XW-1:0] x_ff,        x_in;
   logic [YW-1:0] y_ff,        y_in;
   logic [DW-1:0] depth_ff,    depth_in;
   logic [DW-1:0] count_ff,    count_in;
   logic          cur_new_ff,  cur_new_in;
   logic [AW-1:0] clr_idx_ff,  clr_idx_in;
   logic          clr_emit_ff, clr_emit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [2:0]   free_ff,     free_in;
   logic [15:0]  rnd_ff,      rnd_in;
   rsp_item_type res_ff,      res_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   // visited map ports
   logic          vis_wr_en;
   logic [AW-1:0] vis_wr_addr;
   logic          vis_wr_data;
   logic [AW-1:0] vis_rd_addr;
   logic          vis_rd_data;

   // path stack ports
   logic          stk_wr_en;
   logic [SW-1:0] stk_wr_data;
   logic [AW-1:0] stk_rd_addr;
   logic [SW-1:0] stk_rd_data;
   logic [DW-1:0] depth_dec;

   // neighbour fetch
   logic [XW-1:0] rd_x;
   logic [YW-1:0] rd_y;
   logic [3:0]    nb_ok;
   logic [2:0]    phase_dec;
   logic          cap_free;
   logic [3:0]    free_all;
   logic          pick_any;
   logic [1:0]    pick_dir;

   // position after the step being decided
   logic [XW-1:0] step_x;
   logic [YW-1:0] step_y;

   // coordinates widened by four zero bits, so a four-bit field can be taken
   logic [XW+3:0] cur_x_ext,  step_x_ext;
   logic [YW+3:0] cur_y_ext,  step_y_ext;

   logic         out_free;
   logic         done_go;
   rsp_item_type done_res;

   mbs_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_visited (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd_data)
   );

   mbs_ram #(
      .WIDTH (SW),
      .DEPTH (CELLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // the top of stack is read continuously
   assign depth_dec   = depth_ff - DW'(1);
   assign stk_rd_addr = depth_dec[AW-1:0];
   assign stk_wr_data = {y_ff, x_ff};

   // neighbour in range, in the order left, right, up, down
   assign nb_ok = {(y_ff != Y_LAST), (y_ff != '0), (x_ff != X_LAST), (x_ff != '0)};

   // address of the neighbour fetched in this phase
   always_comb begin
      rd_x = x_ff;
      rd_y = y_ff;
      case (phase_ff)
         3'd0:    rd_x = x_ff - XW'(1);
         3'd1:    rd_x = x_ff + XW'(1);
         3'd2:    rd_y = y_ff - YW'(1);
         default: rd_y = y_ff + YW'(1);
      endcase
   end

   assign vis_rd_addr = cell_addr(rd_x, rd_y);

   // visited bit returned now belongs to the neighbour fetched one phase ago
   assign phase_dec = phase_ff - 3'd1;
   assign cap_free  = !vis_rd_data && nb_ok[phase_dec[1:0]];
   assign free_all  = {cap_free, free_ff};

   mbs_pick u_pick (
      .free (free_all),
      .rnd  (rnd_ff),
      .any  (pick_any),
      .dir  (pick_dir)
   );

   // move to the picked neighbour, else back to the top of stack if it is not empty
   always_comb begin
      step_x = x_ff;
      step_y = y_ff;
      if (pick_any) begin
         case (pick_dir)
            DIR_LEFT:  step_x = x_ff - XW'(1);
            DIR_RIGHT: step_x = x_ff + XW'(1);
            DIR_UP:    step_y = y_ff - YW'(1);
            default:   step_y = y_ff + YW'(1);
         endcase
      end else if (depth_ff != '0) begin
         step_x = stk_rd_data[XW-1:0];
         step_y = stk_rd_data[SW-1:XW];
      end
   end

   assign cur_x_ext  = {4'd0, x_ff};
   assign cur_y_ext  = {4'd0, y_ff};
   assign step_x_ext = {4'd0, step_x};
   assign step_y_ext = {4'd0, step_y};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      cur_new_in   = cur_new_ff;
      clr_idx_in   = clr_idx_ff;
      clr_emit_in  = clr_emit_ff;
      free_in      = free_ff;
      rnd_in       = rnd_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vis_wr_en    = 1'b0;
      vis_wr_addr  = cell_addr(x_ff, y_ff);
      vis_wr_data  = 1'b1;
      stk_wr_en    = 1'b0;
      done_go      = 1'b0;
      done_res     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the visited map back to all clear
            vis_wr_en   = 1'b1;
            vis_wr_addr = clr_idx_ff;
            vis_wr_data = 1'b0;
            clr_idx_in  = clr_idx_ff + AW'(1);
            if (clr_idx_ff == CELL_LAST) begin
               clr_idx_in  = '0;
               clr_emit_in = 1'b0;
               x_in        = '0;
               y_in        = '0;
               depth_in    = '0;
               count_in    = '0;
               cur_new_in  = 1'b1;
               if (clr_emit_ff) begin
                  done_go = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            // left neighbour read is already on the port
            phase_in = '0;
            if (req_valid) begin
               rnd_in = req_data.random_value;
               if (req_data.cmd == CMD_START) begin
                  state_in    = ST_CLEAR;
                  clr_emit_in = 1'b1;
               end else if (count_ff == CELL_TOTAL) begin
                  done_go           = 1'b1;
                  done_res.walker_x = cur_x_ext[3:0];
                  done_res.walker_y = cur_y_ext[3:0];
                  done_res.finished = 1'b1;
               end else begin
                  state_in = ST_READ;
                  phase_in = 3'd1;
               end
            end
         end
         ST_READ: begin
            phase_in = phase_ff + 3'd1;
            // mark the walker's cell on first arrival
            if ((phase_ff == 3'd1) && cur_new_ff) begin
               vis_wr_en = 1'b1;
               count_in  = count_ff + DW'(1);
            end
            if (phase_ff != PH_DECIDE) begin
               free_in[phase_dec[1:0]] = cap_free;
            end else begin
               // back to the left neighbour read for the next word
               phase_in   = '0;
               x_in       = step_x;
               y_in       = step_y;
               cur_new_in = pick_any;
               if (pick_any) begin
                  if (depth_ff != CELL_TOTAL) begin
                     stk_wr_en = 1'b1;
                     depth_in  = depth_ff + DW'(1);
                  end
               end else if (depth_ff != '0) begin
                  depth_in = depth_dec;
               end
               done_go            = 1'b1;
               done_res.carved    = pick_any;
               done_res.from_x    = pick_any ? cur_x_ext[3:0] : 4'd0;
               done_res.from_y    = pick_any ? cur_y_ext[3:0] : 4'd0;
               done_res.direction = pick_any ? pick_dir : DIR_LEFT;
               done_res.walker_x  = step_x_ext[3:0];
               done_res.walker_y  = step_y_ext[3:0];
               done_res.finished  = (count_ff == CELL_TOTAL);
            end
         end
         ST_EMIT: begin
            // parked result waits for the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the finished word to the output register or park it
      if (done_go) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = done_res;
            state_in     = ST_IDLE;
         end else begin
            res_in   = done_res;
            state_in = ST_EMIT;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         cur_new_ff   <= 1'b1;
         clr_idx_ff   <= '0;
         clr_emit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         cur_new_ff   <= cur_new_in;
         clr_idx_ff   <= clr_idx_in;
         clr_emit_ff  <= clr_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      rnd_ff      <= rnd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ tb/maze_step_checker.sv @@
`timescale 1ns / 1ps
// checker for maze_backtracker_step: watches both channels, predicts every response word
// from its own copy of the walk state and compares each whole word; depends on mbs_pkg
module maze_step_checker #(
   parameter int GRID_W = 16,
   parameter int GRID_H = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  mbs_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mbs_pkg::rsp_item_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import mbs_pkg::*;

   localparam int CELLS = GRID_W * GRID_H;

   // predicted walk state
   bit   cell_seen [CELLS];
   int   trail [CELLS];
   int   trail_depth;
   int   walker_cell;
   int   cells_seen;

   rsp_item_type walk_results_due [$];
   int           mismatch_total;

   function automatic void clear_walk();
      foreach (cell_seen[i]) cell_seen[i] = 1'b0;
      trail_depth = 0;
      walker_cell = 0;
      cells_seen  = 0;
   endfunction

   function automatic rsp_item_type next_maze_result(input req_item_type w);
      rsp_item_type r;
      int           cx, cy, n, pick;
      logic [1:0]   open_sides [4];
      logic [1:0]   side;
      r = '0;
      if (w.cmd == CMD_START) begin
         clear_walk();
         return r;
      end
      if (cells_seen >= CELLS) begin
         r.walker_x = 4'(walker_cell % GRID_W);
         r.walker_y = 4'(walker_cell / GRID_W);
         r.finished = 1'b1;
         return r;
      end
      cx = walker_cell % GRID_W;
      cy = walker_cell / GRID_W;
      if (!cell_seen[walker_cell]) begin
         cell_seen[walker_cell] = 1'b1;
         cells_seen++;
      end
      // unvisited neighbours, left right up down
      n = 0;
      if (cx > 0 && !cell_seen[walker_cell - 1]) begin
         open_sides[n] = DIR_LEFT;
         n++;
      end
      if (cx + 1 < GRID_W && !cell_seen[walker_cell + 1]) begin
         open_sides[n] = DIR_RIGHT;
         n++;
      end
      if (cy > 0 && !cell_seen[walker_cell - GRID_W]) begin
         open_sides[n] = DIR_UP;
         n++;
      end
      if (cy + 1 < GRID_H && !cell_seen[walker_cell + GRID_W]) begin
         open_sides[n] = DIR_DOWN;
         n++;
      end
      if (n > 0) begin
         pick = int'(w.random_value) % n;
         side = open_sides[pick];
         if (trail_depth < CELLS) begin
            trail[trail_depth] = walker_cell;
            trail_depth++;
         end
         case (side)
            DIR_LEFT:  walker_cell = walker_cell - 1;
            DIR_RIGHT: walker_cell = walker_cell + 1;
            DIR_UP:    walker_cell = walker_cell - GRID_W;
            default:   walker_cell = walker_cell + GRID_W;
         endcase
         r.carved    = 1'b1;
         r.from_x    = 4'(cx);
         r.from_y    = 4'(cy);
         r.direction = side;
      end else if (trail_depth > 0) begin
         trail_depth--;
         walker_cell = trail[trail_depth];
      end
      r.walker_x = 4'(walker_cell % GRID_W);
      r.walker_y = 4'(walker_cell / GRID_W);
      r.finished = (cells_seen >= CELLS);
      return r;
   endfunction

   function automatic string show_word(input rsp_item_type r);
      return $sformatf("carved %0d from (%0d,%0d) side %0d walker (%0d,%0d) finished %0d",
                       r.carved, r.from_x, r.from_y, r.direction,
                       r.walker_x, r.walker_y, r.finished);
   endfunction

   initial begin
      clear_walk();
      mismatch_total = 0;
      fail_count     = 0;
      pending        = 0;
   end

   always @(posedge clock) begin
      rsp_item_type due;
      if (reset) begin
         clear_walk();
         walk_results_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            walk_results_due.push_back(next_maze_result(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (walk_results_due.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("[%0t] unexpected response word: %s", $realtime, show_word(rsp_data));
               end
            end else begin
               due = walk_results_due.pop_front();
               if (rsp_data !== due) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("[%0t] response mismatch", $realtime);
                     $display("   expected %s", show_word(due));
                     $display("   actual   %s", show_word(rsp_data));
                  end
               end
            end
         end
      end
      fail_count <= mismatch_total;
      pending    <= walk_results_due.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// top of the maze_backtracker_step testbench: clock, reset, stimulus and verdict
// depends on mbs_pkg, the design files and tb/maze_step_checker.sv
module tb_top;
   import mbs_pkg::*;

   localparam int GRID_W      = 16;
   localparam int GRID_H      = 16;
   localparam int ITEMS       = 1200;
   localparam int CALM_ITEMS  = 150;      // closing stretch with no idling
   localparam int CYCLE_LIMIT = 1000000;  // far above the slowest correct run
   localparam int SETTLE      = 60;       // settle wait for stray words after the last word

   localparam logic CMD_STEP = ~CMD_START;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   int fail_count;
   int results_pending;
   int words_sent;
   int cycle_count;
   bit quiet;

   maze_backtracker_step #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   maze_step_checker #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (results_pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, counted in clock cycles
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("maze_backtracker_step verification failed");
      $finish;
   end

   // offer one request word and hold it until the block takes it, then maybe idle
   task automatic send_word(input logic cmd, input logic [15:0] rand_word);
      req_item_type w;
      w.cmd          = cmd;
      w.random_value = rand_word;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (words_sent >= ITEMS - CALM_ITEMS) quiet = 1'b1;
      // idle burst on the request side, never during the closing stretch
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // random word, now and then pinned to an extreme or a small value
   function automatic logic [15:0] pick_rand_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 12));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // response side stall: random bursts, with calm stretches between, none once quiet
   initial begin
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int run_len;
      int pick;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      quiet      = 1'b0;
      words_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: steps straight out of reset, starts with extreme random words,
      // then steps that pick every slot among two or three candidates, and a restart mid-walk
      send_word(CMD_STEP, 16'h0000);
      send_word(CMD_STEP, 16'hFFFF);
      send_word(CMD_START, 16'hFFFF);
      send_word(CMD_START, 16'h0000);
      send_word(CMD_STEP, 16'h0000);
      send_word(CMD_STEP, 16'h0001);
      send_word(CMD_STEP, 16'h0002);
      send_word(CMD_STEP, 16'h0003);
      send_word(CMD_STEP, 16'hFFFF);
      send_word(CMD_STEP, 16'h8000);
      send_word(CMD_STEP, 16'h5555);
      send_word(CMD_STEP, 16'hAAAA);
      send_word(CMD_STEP, 16'h7FFF);
      send_word(CMD_STEP, 16'h0001);
      send_word(CMD_START, 16'h5A5A);
      send_word(CMD_STEP, 16'hFFFE);
      send_word(CMD_STEP, 16'h0000);
      send_word(CMD_STEP, 16'h0000);
      send_word(CMD_STEP, 16'h0002);
      send_word(CMD_STEP, 16'hFFFF);

      // random: mostly whole mazes run past completion, some cut short,
      // some starts back to back
      while (words_sent < ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            run_len = $urandom_range(520, 600);
         end else if (pick < 9) begin
            run_len = $urandom_range(1, 80);
         end else begin
            run_len = 0;
         end
         send_word(CMD_START, 16'($urandom_range(0, 65535)));
         repeat (run_len) begin
            if (words_sent < ITEMS) send_word(CMD_STEP, pick_rand_word());
         end
      end
      req_valid <= 1'b0;

      // drain: let the count take in the last word, wait for every predicted
      // word back, then a short settle for strays
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0 && results_pending == 0) begin
         $display("maze_backtracker_step verification clean");
      end else begin
         $display("maze_backtracker_step verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/mbs_pkg.sv
design/mbs_ram.sv
design/mbs_pick.sv
design/maze_backtracker_step.sv
tb/maze_step_checker.sv
tb/tb_top.sv
